FILE: src/rhb_pkg.sv
// Shared constants, codes and control types for the range histogram binner.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rhb_pkg;

  localparam int MAX_BINS   = 1024;
  localparam int COUNT_BITS = 32;
  localparam int ADDR_W     = $clog2(MAX_BINS);

  localparam int OPCODE_W   = 1;
  localparam int SAMPLE_W   = 32;
  localparam int INDEX_W    = 10;
  localparam int STATUS_W   = 2;
  localparam int NUMBER_W   = 16;
  localparam int VALUE_W    = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int STEP_W      = 31;
  localparam int BIN_COUNT_W = 11;

  localparam int NUM_W  = SAMPLE_W + 2;
  localparam int DIV_W  = STEP_W + 1;
  localparam int STEP_CNT_W = $clog2(NUM_W + 1);

  localparam logic [OPCODE_W-1:0] OP_INSERT = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_READ   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BELOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABOVE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_START = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_STOP  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BIN_STEP    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BIN_COUNT   = 2'd3;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic check;
    logic div_load;
    logic div_step;
    logic mem_rd;
    logic update;
    logic reject;
    logic emit;
  } rhb_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic chk_reject;
    logic div_last;
    logic quot_beyond;
    logic out_free;
  } rhb_stat_t;

endpackage

`default_nettype wire

FILE: src/rhb_req_if.sv
// Request channel: opcode, sample and bin index with valid/ready.
// Depends on rhb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rhb_req_if;
  import rhb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [SAMPLE_W-1:0] sample;
  logic [INDEX_W-1:0]         bin_index;

  modport source (output valid, output opcode, output sample, output bin_index,
                  input ready);
  modport sink (input valid, input opcode, input sample, input bin_index,
                output ready);
endinterface

`default_nettype wire

FILE: src/rhb_res_if.sv
// Result channel: status, bin number and bin value with valid/ready.
// Depends on rhb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rhb_res_if;
  import rhb_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NUMBER_W-1:0] bin_number;
  logic [VALUE_W-1:0]  bin_value;

  modport source (output valid, output status, output bin_number, output bin_value,
                  input ready);
  modport sink (input valid, input status, input bin_number, input bin_value,
                output ready);
endinterface

`default_nettype wire

FILE: src/rhb_cfg_if.sv
// Configuration write channel: register index and write data with valid/ready.
// Depends on rhb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rhb_cfg_if;
  import rhb_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/rhb_ctrl.sv
// Sequencing state machine for the histogram binner.
// Depends on rhb_pkg; drives rhb_dp through command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module rhb_ctrl import rhb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire rhb_stat_t stat,
  output rhb_cmd_t       cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_LOAD   = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_TEST   = 4'd5;
  localparam logic [3:0] S_READ   = 4'd6;
  localparam logic [3:0] S_UPDATE = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.chk_reject) begin
          cmd.reject = 1'b1;
          state_next = S_DONE;
        end else if (stat.is_read) begin
          state_next = S_READ;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (stat.quot_beyond) begin
          cmd.reject = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/rhb_dp.sv
// Datapath: configuration registers, range check, radix-2 restoring divider,
// counter memory with clear sweep, and the result register. Depends on rhb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhb_dp import rhb_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [OPCODE_W-1:0]        opcode,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic [INDEX_W-1:0]         bin_index,
  rhb_cfg_if.sink                         cfg,
  rhb_res_if.source                       result,
  input  wire rhb_cmd_t                   cmd,
  output rhb_stat_t                       stat
);

  localparam logic [BIN_COUNT_W-1:0] MAX_BINS_C = BIN_COUNT_W'(MAX_BINS);
  localparam logic [COUNT_BITS-1:0]  CNT_MAX    = '1;

  logic signed [SAMPLE_W-1:0] range_start;
  logic signed [SAMPLE_W-1:0] range_stop;
  logic [STEP_W-1:0]          bin_step;
  logic [BIN_COUNT_W-1:0]     bin_count;

  logic [OPCODE_W-1:0]        op_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [INDEX_W-1:0]         idx_q;
  logic [SAMPLE_W-1:0]        offset_q;

  logic [NUM_W-1:0]      num_q;
  logic [DIV_W-1:0]      rem_q;
  logic [DIV_W-1:0]      div_q;
  logic [STEP_CNT_W-1:0] cnt_q;

  logic [COUNT_BITS-1:0] mem [MAX_BINS];
  logic [COUNT_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]     addr_q;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     clr_addr;
  logic                  mem_we;
  logic [ADDR_W-1:0]     wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] inc_value;

  logic [STATUS_W-1:0] res_status;
  logic [NUMBER_W-1:0] res_number;
  logic [VALUE_W-1:0]  res_value;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [NUMBER_W-1:0] out_number;
  logic [VALUE_W-1:0]  out_value;

  logic [BIN_COUNT_W-1:0] limit;
  logic [STATUS_W-1:0]    chk_code;
  logic [SAMPLE_W-1:0]    offset;
  logic [DIV_W:0]         rem_sh;
  logic [DIV_W+1:0]       diff;
  logic                   borrow;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_start <= '0;
      range_stop  <= 32'sh7FFF_FFFF;
      bin_step    <= STEP_W'(65536);
      bin_count   <= BIN_COUNT_W'(1024);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_RANGE_START: range_start <= $signed(cfg.data);
        REG_RANGE_STOP:  range_stop  <= $signed(cfg.data);
        REG_BIN_STEP:    bin_step    <= cfg.data[STEP_W-1:0];
        REG_BIN_COUNT:   bin_count   <= cfg.data[BIN_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign limit  = (bin_count < MAX_BINS_C) ? bin_count : MAX_BINS_C;
  assign offset = $unsigned(sample_q) - $unsigned(range_start);

  always_comb begin
    chk_code = ST_DONE;
    if (op_q == OP_READ) begin
      if ({1'b0, idx_q} >= limit) begin
        chk_code = ST_BEYOND;
      end
    end else if (sample_q < range_start) begin
      chk_code = ST_BELOW;
    end else if (sample_q > range_stop) begin
      chk_code = ST_ABOVE;
    end else if (bin_step == '0) begin
      chk_code = ST_BEYOND;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= opcode;
      sample_q <= sample;
      idx_q    <= bin_index;
    end
    if (cmd.check) begin
      offset_q <= offset;
    end
  end

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, div_q};
  assign borrow = diff[DIV_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_q <= '0;
    end else if (cmd.div_load) begin
      cnt_q <= STEP_CNT_W'(NUM_W);
    end else if (cmd.div_step) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      num_q <= {1'b0, offset_q, 1'b0} + {3'b000, bin_step};
      div_q <= {bin_step, 1'b0};
      rem_q <= '0;
    end else if (cmd.div_step) begin
      rem_q <= borrow ? rem_sh[DIV_W-1:0] : diff[DIV_W-1:0];
      num_q <= {num_q[NUM_W-2:0], ~borrow};
    end
  end

  assign rd_addr   = (op_q == OP_READ) ? idx_q : num_q[ADDR_W-1:0];
  assign inc_value = (rd_data == CNT_MAX) ? rd_data : rd_data + 1'b1;
  assign mem_we    = cmd.clr_wr || (cmd.update && op_q == OP_INSERT);
  assign wr_addr   = cmd.clr_wr ? clr_addr : addr_q;
  assign wr_data   = cmd.clr_wr ? '0 : inc_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_data <= mem[rd_addr];
      addr_q  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reject) begin
      res_status <= (chk_code != ST_DONE) ? chk_code : ST_BEYOND;
      res_number <= '0;
      res_value  <= '0;
    end else if (cmd.update) begin
      res_status <= ST_DONE;
      res_number <= NUMBER_W'(addr_q);
      res_value  <= (op_q == OP_READ) ? rd_data : inc_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= res_status;
      out_number <= res_number;
      out_value  <= res_value;
    end
  end

  assign result.valid      = out_valid;
  assign result.status     = out_status;
  assign result.bin_number = out_number;
  assign result.bin_value  = out_value;

  assign stat.clr_last    = (clr_addr == ADDR_W'(MAX_BINS - 1));
  assign stat.is_read     = (op_q == OP_READ);
  assign stat.chk_reject  = (chk_code != ST_DONE);
  assign stat.div_last    = (cnt_q == STEP_CNT_W'(1));
  assign stat.quot_beyond = (num_q >= NUM_W'(limit));
  assign stat.out_free    = !out_valid || result.ready;

endmodule

`default_nettype wire

FILE: src/range_histogram_binner.sv
// Top level of the range histogram binner: controller plus datapath.
// Depends on rhb_pkg, rhb_req_if, rhb_res_if, rhb_cfg_if, rhb_ctrl and rhb_dp.
`timescale 1ns / 1ps
`default_nettype none

// After reset the block sweeps its 1024-entry counter memory to zero, one
// entry a cycle, and the request channel stays not ready until the sweep
// ends; configuration writes are taken at any time. An insert is checked
// against the range, then the radix-2 divider forms (2*offset + step) /
// (2*step), and one read-modify-write of the counter memory follows and
// loads the result; a bin beyond the count is rejected after the divide.
// A read of one bin is checked and then reads the memory; a sample outside
// the range, a zero step or a read beyond the count is rejected at the
// check. The next request is accepted once the result has moved to the
// output register, and that register lets it be accepted while the
// previous result waits to be taken.

module range_histogram_binner import rhb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  rhb_req_if.sink   request,
  rhb_res_if.source result,
  rhb_cfg_if.sink   cfg
);

  rhb_cmd_t  cmd;
  rhb_stat_t stat;
  logic      req_ready;

  assign request.ready = req_ready;

  rhb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rhb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .opcode    (request.opcode),
    .sample    (request.sample),
    .bin_index (request.bin_index),
    .cfg       (cfg),
    .result    (result),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire
